[rtl/core/fcr_pkg.sv]
// shared types and constants for the fir convolution reverb block
`timescale 1ns / 1ps

package fcr_pkg;

    // divisor applied after the q15 rescale
    localparam int DIVIDE_BY = 10;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic take_sample;
        logic take_load;
        logic take_clear;
        logic issue;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic issue_done;
        logic pipe_busy;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

[rtl/core/fcr_ctrl.sv]
// sequencing state machine for the fir convolution reverb block
`timescale 1ns / 1ps

module fcr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fcr_pkg::action_t action,
    input  fcr_pkg::status_t status,
    output fcr_pkg::cmd_t    cmd
);
    import fcr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && action == ACT_SAMPLE)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (status.issue_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (action)
                        ACT_SAMPLE: cmd.take_sample = 1'b1;
                        ACT_LOAD:   cmd.take_load   = 1'b1;
                        ACT_CLEAR:  cmd.take_clear  = 1'b1;
                        default:    cmd = '0;
                    endcase
                end
            end
            S_MAC:   cmd.issue    = !status.issue_done;
            S_DRAIN: cmd.div_load = !status.pipe_busy;
            S_DIV:   cmd.div_step = !status.div_done;
            S_DONE:  cmd.out_load = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/core/fcr_datapath.sv]
// coefficient and history memories, multiply-accumulate, divider and output register
`timescale 1ns / 1ps

module fcr_datapath #(
    parameter int MAX_TAPS     = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fcr_pkg::cmd_t                        cmd,
    output fcr_pkg::status_t                     status,
    input  logic                                 cfg_write_en,
    input  logic [$clog2(MAX_TAPS+1)-1:0]        cfg_write_data,
    input  logic [$clog2(MAX_TAPS)-1:0]          tap_index,
    input  logic signed [SAMPLE_WIDTH-1:0]       value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       result_sample,
    output logic                                 saturated
);
    import fcr_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = 2 * SW;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int QW     = ACC_W - (SW - 1);
    localparam int XW     = SW + 3;
    localparam int RSH    = XW + 4;
    localparam int PW     = 2 * XW + 1;
    localparam logic [CNT_W-1:0] TAPS_MAX = CNT_W'(MAX_TAPS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);
    localparam logic [QW-1:0]    POS_LIM  = QW'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic [QW-1:0]    NEG_LIM  = QW'(64'd1 << (SW - 1));
    localparam logic [QW-1:0]    X_CAP    =
        QW'(64'(DIVIDE_BY) * ((64'd1 << (SW - 1)) + 64'd1));
    localparam logic [XW:0]      RECIP    =
        (XW+1)'(((64'd1 << RSH) + 64'(DIVIDE_BY) - 64'd1) / 64'(DIVIDE_BY));

    logic signed [SW-1:0] coef_mem [MAX_TAPS];
    logic signed [SW-1:0] hist_mem [MAX_TAPS];

    logic [CNT_W-1:0]        tap_count_reg;
    logic [IDX_W-1:0]        wp_reg;
    logic [CNT_W-1:0]        seen_reg;
    logic [CNT_W-1:0]        limit_reg;
    logic [CNT_W-1:0]        limit_next;
    logic [CNT_W-1:0]        tap_clip;
    logic [CNT_W-1:0]        j_reg;
    logic [IDX_W-1:0]        rd_ptr_reg;
    logic signed [SW-1:0]    coef_rd_reg;
    logic signed [SW-1:0]    hist_rd_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0]        acc_mag;
    logic                    neg_reg;
    logic [QW-1:0]           dividend_reg;
    logic [QW-1:0]           quot_reg;
    logic [PW-1:0]           div_prod;
    logic                    div_done_reg;
    logic                    out_valid_reg;
    logic signed [SW-1:0]    out_sample_reg;
    logic                    out_sat_reg;
    logic signed [SW-1:0]    fin_sample;
    logic                    fin_sat;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CNT_W'(1);
        end
        else if (cfg_write_en)
        begin
            tap_count_reg <= cfg_write_data;
        end
    end

    // taps used for this sample
    always_comb
    begin
        tap_clip = (tap_count_reg > TAPS_MAX) ? TAPS_MAX : tap_count_reg;
        if (seen_reg >= tap_clip)
        begin
            limit_next = tap_clip;
        end
        else
        begin
            limit_next = seen_reg + CNT_W'(1);
        end
    end

    // stream position and tap sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            seen_reg   <= '0;
            limit_reg  <= '0;
            j_reg      <= '0;
            rd_ptr_reg <= '0;
        end
        else if (cmd.take_clear)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end
        else if (cmd.take_sample)
        begin
            wp_reg     <= (wp_reg == LAST_IDX) ? '0 : wp_reg + IDX_W'(1);
            seen_reg   <= (seen_reg < TAPS_MAX) ? seen_reg + CNT_W'(1) : seen_reg;
            limit_reg  <= limit_next;
            j_reg      <= '0;
            rd_ptr_reg <= wp_reg;
        end
        else if (cmd.issue)
        begin
            j_reg      <= j_reg + CNT_W'(1);
            rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - IDX_W'(1);
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.take_load && ({1'b0, tap_index} < TAPS_MAX))
        begin
            coef_mem[tap_index] <= value;
        end
        if (cmd.issue)
        begin
            coef_rd_reg <= coef_mem[j_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            hist_mem[wp_reg] <= value;
        end
        if (cmd.issue)
        begin
            hist_rd_reg <= hist_mem[rd_ptr_reg];
        end
    end

    // multiply-accumulate pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= coef_rd_reg * hist_rd_reg;
        end
        if (cmd.take_sample)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // magnitude divided by ten through a reciprocal multiply, large values clipped first
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_prod = PW'(dividend_reg[XW-1:0]) * PW'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_done_reg <= 1'b0;
        end
        else if (cmd.div_load)
        begin
            div_done_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            div_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            neg_reg      <= acc_reg[ACC_W-1];
            dividend_reg <= acc_mag[ACC_W-1:SW-1];
        end
        else if (cmd.div_step)
        begin
            if (dividend_reg >= X_CAP)
            begin
                quot_reg <= NEG_LIM + QW'(1);
            end
            else
            begin
                quot_reg <= QW'(div_prod[PW-1:RSH]);
            end
        end
    end

    // saturation
    always_comb
    begin
        fin_sat    = 1'b0;
        fin_sample = quot_reg[SW-1:0];
        if (neg_reg)
        begin
            if (quot_reg > NEG_LIM)
            begin
                fin_sat    = 1'b1;
                fin_sample = {1'b1, {(SW-1){1'b0}}};
            end
            else
            begin
                fin_sample = -quot_reg[SW-1:0];
            end
        end
        else if (quot_reg > POS_LIM)
        begin
            fin_sat    = 1'b1;
            fin_sample = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sample_reg <= fin_sample;
            out_sat_reg    <= fin_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_sample = out_sample_reg;
    assign saturated     = out_sat_reg;

    assign status.issue_done = (j_reg == limit_reg);
    assign status.pipe_busy  = v1_reg || v2_reg;
    assign status.div_done   = div_done_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

endmodule

[rtl/core/fir_convolution_reverb.sv]
// top level of the fir convolution reverb block
//
//  channel   signals                                     direction
//  input     in_valid/in_ready, action, tap_index, value  in
//  output    out_valid/out_ready, result_sample, saturated out
//  config    cfg_write_en, cfg_write_data (tap_count)     in
//
//  a sample item sends its taps in turn through the shared multiply-accumulate, then
//  through a reciprocal multiply for the divide by ten. taps is the smaller of tap_count,
//  MAX_TAPS and the samples seen since the last clear plus one; it may be zero.
//  a held result in the output register stalls the next one.
//  load and clear items give no result and do not hold the input.
//  a new item is taken while a finished result waits in the output register.
//  reset clears control state only; both memories hold whatever they held.
`timescale 1ns / 1ps

module fir_convolution_reverb #(
    parameter int MAX_TAPS     = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fcr_pkg::action_t                  action,
    input  logic [$clog2(MAX_TAPS)-1:0]       tap_index,
    input  logic signed [SAMPLE_WIDTH-1:0]    value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    result_sample,
    output logic                              saturated,
    input  logic                              cfg_write_en,
    input  logic [$clog2(MAX_TAPS+1)-1:0]     cfg_write_data
);
    import fcr_pkg::*;

    cmd_t    cmd;
    status_t status;

    fcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    fcr_datapath #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .tap_index      (tap_index),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_sample  (result_sample),
        .saturated      (saturated)
    );

endmodule

[rtl/core/fcr_checker.sv]
// port-level assertions for the fir convolution reverb block
`timescale 1ns / 1ps

module fcr_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input fcr_pkg::action_t                  action,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [SAMPLE_WIDTH-1:0]    result_sample,
    input logic                              saturated
);
    import fcr_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_sample) && $stable(saturated))
    else $error("result changed while stalled");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (result_sample == S_MAX) || (result_sample == S_MIN))
    else $error("saturated result not at a limit");

    // a sample item keeps the input side busy
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_SAMPLE |=> !in_ready)
    else $error("input ready straight after a sample item");

    // load and clear items do not hold the input
    a_ctrl_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_LOAD || action == ACT_CLEAR) |=> in_ready)
    else $error("load or clear item held the input");

    // no result appears without a sample item having been taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a sample item");

endmodule

bind fir_convolution_reverb fcr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fcr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_sample  (result_sample),
    .saturated      (saturated)
);

[test/testbench.sv]
// testbench for the fir convolution reverb block: table-driven and random items against a filter model
`timescale 1ns / 1ps

module testbench;
    import fcr_pkg::*;

    localparam int MAX_TAPS      = 4096;
    localparam int LIMIT         = 500000;
    localparam int SETTLE        = 64;
    localparam int MAX_LIVE_TAPS = 48;
    localparam int RANDOM_ITEMS  = 110;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam longint SCALE = longint'(DIVIDE_BY) * 64'sd32768;
    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sat;
    } result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         act;
        logic [11:0]        idx;
        logic signed [15:0] val;
        logic [12:0]        cfg;
        logic [3:0]         reps;
        logic               typed;
        logic signed [15:0] exp_s;
        logic               exp_sat;
    } plan_row_t;

    localparam result_t NO_RESULT = '0;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    action_t            action;
    logic [11:0]        tap_index;
    logic signed [15:0] value;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] result_sample;
    logic               saturated;
    logic               cfg_write_en;
    logic [12:0]        cfg_write_data;

    // filter model state
    logic signed [15:0] coef_mem [MAX_TAPS];
    bit                 coef_loaded [MAX_TAPS];
    logic signed [15:0] hist_mem [MAX_TAPS];
    logic [11:0]        wr_pos;
    int                 seen;
    int                 taps_cfg;

    result_t   expected_q [$];
    result_t   oldest;
    plan_row_t plan [18];
    int        mismatches = 0;
    int        cycles = 0;
    int        items_done = 0;
    int        burst_left = 0;
    bit        hot_pol = 1'b0;
    logic [15:0] stall_pat = 16'hffff;
    logic [3:0]  pat_pos = 4'd0;
    int          pat_age = 0;

    fir_convolution_reverb dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .tap_index      (tap_index),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_sample  (result_sample),
        .saturated      (saturated),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, renewed each time pat_age runs down
    always @(negedge clk)
    begin
        if (pat_age == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_pat = 16'hffff;
            else
                stall_pat = 16'($urandom) | 16'h0001;
            pat_age = 256;
        end
        pat_age--;
        out_ready = stall_pat[pat_pos];
        pat_pos = pat_pos + 4'd1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: sample %0d sat %0b", result_sample, saturated);
            end
            else
            begin
                oldest = expected_q.pop_front();
                if (result_sample !== oldest.sample || saturated !== oldest.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected sample %0d sat %0b, got sample %0d sat %0b",
                                 oldest.sample, oldest.sat, result_sample, saturated);
                end
            end
        end
    end

    function automatic result_t filter_next(input logic signed [15:0] x);
        result_t     r;
        longint      acc;
        longint      q;
        int          lim;
        int          j;
        logic [11:0] slot;
        hist_mem[wr_pos] = x;
        lim = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
        if (lim > seen + 1)
            lim = seen + 1;
        acc = 0;
        for (j = 0; j < lim; j++)
        begin
            slot = wr_pos - 12'(j);
            acc += longint'(coef_mem[j]) * longint'(hist_mem[slot]);
        end
        q = acc / SCALE;
        r.sat = 1'b0;
        if (q > 32767)
        begin
            q = 32767;
            r.sat = 1'b1;
        end
        else if (q < -32768)
        begin
            q = -32768;
            r.sat = 1'b1;
        end
        r.sample = q[15:0];
        wr_pos = wr_pos + 12'd1;
        if (seen < MAX_TAPS)
            seen++;
        return r;
    endfunction

    // extremes in runs of one sign so that sums can clip
    function automatic logic signed [15:0] pick_value(input bit hot);
        if (!hot)
            return 16'($urandom);
        if ($urandom_range(0, 11) == 0)
            hot_pol = !hot_pol;
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return hot_pol ? Q_MAX : Q_MIN;
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [11:0] idx,
                             input logic signed [15:0] val, input bit typed,
                             input result_t typed_res);
        int      gap;
        result_t r;
        gap = 0;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
                burst_left = $urandom_range(10, 30);
            else
                burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action    = action_t'(act);
        tap_index = idx;
        value     = val;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        case (act)
            ACT_SAMPLE:
            begin
                r = filter_next(val);
                expected_q.push_back(typed ? typed_res : r);
            end
            ACT_LOAD:
            begin
                coef_mem[idx] = val;
                coef_loaded[idx] = 1'b1;
            end
            ACT_CLEAR:
            begin
                wr_pos = '0;
                seen = 0;
            end
            default: ;
        endcase
        if (act != ACT_SPARE)
            items_done++;
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_tap_count(input logic [12:0] v);
        drain_and_settle();
        cfg_write_data = v;
        cfg_write_en   = 1'b1;
        @(negedge clk);
        cfg_write_en = 1'b0;
        taps_cfg = int'(v);
    endtask

    // every tap the sample will read gets its coefficient first
    task automatic send_sample(input logic signed [15:0] x, input bit hot);
        int eff;
        int lim;
        int j;
        eff = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
        lim = (eff > seen + 1) ? seen + 1 : eff;
        if (lim > MAX_LIVE_TAPS)
        begin
            send_item(ACT_CLEAR, 12'($urandom), 16'($urandom), 1'b0, NO_RESULT);
            lim = (eff > 1) ? 1 : eff;
        end
        for (j = 0; j < lim; j++)
            if (!coef_loaded[j])
                send_item(ACT_LOAD, 12'(j), pick_value(hot), 1'b0, NO_RESULT);
        send_item(ACT_SAMPLE, 12'($urandom), x, 1'b0, NO_RESULT);
    endtask

    initial
    begin
        int          rep;
        int          k;
        int          n;
        int          r;
        bit          hot;
        bit          coef_sign;
        logic [12:0] t;
        logic [11:0] idx;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_SAMPLE;
        tap_index      = '0;
        value          = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        wr_pos         = '0;
        seen           = 0;
        taps_cfg       = 1;
        foreach (coef_loaded[i])
            coef_loaded[i] = 1'b0;

        plan = '{
            '{ROW_ITEM, ACT_LOAD,   12'd0,    Q_MIN,        13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    Q_MIN,        13'd0,    4'd1, 1'b1, 16'sd3276, 1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd4095, Q_MAX,        13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SPARE,  12'd4095, 16'shffff,    13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_CLEAR,  12'd0,    16'sd0,       13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_CFG,  ACT_SAMPLE, 12'd0,    16'sd0,       13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    16'sd12345,   13'd0,    4'd1, 1'b1, 16'sd0,    1'b0},
            '{ROW_CFG,  ACT_SAMPLE, 12'd0,    16'sd0,       13'd8191, 4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_LOAD,   12'd1,    Q_MIN,        13'd0,    4'd9, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_CLEAR,  12'd4095, 16'shffff,    13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    Q_MIN,        13'd0,    4'd9, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    Q_MIN,        13'd0,    4'd1, 1'b1, Q_MAX,     1'b1},
            '{ROW_ITEM, ACT_LOAD,   12'd4095, Q_MAX,        13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_CFG,  ACT_SAMPLE, 12'd0,    16'sd0,       13'd1,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    16'sd0,       13'd0,    4'd1, 1'b1, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_LOAD,   12'd0,    Q_MAX,        13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    Q_MAX,        13'd0,    4'd1, 1'b0, 16'sd0,    1'b0},
            '{ROW_ITEM, ACT_SAMPLE, 12'd0,    Q_MIN,        13'd0,    4'd1, 1'b0, 16'sd0,    1'b0}
        };

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            for (rep = 0; rep < int'(plan[i].reps); rep++)
                if (plan[i].kind == ROW_CFG)
                    write_tap_count(plan[i].cfg);
                else
                    send_item(plan[i].act, plan[i].idx + 12'(rep), plan[i].val, plan[i].typed,
                              {plan[i].exp_s, plan[i].exp_sat});

        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            hot = ($urandom_range(0, 2) == 0);
            if (hot)
                t = 13'($urandom_range(10, 20));
            else
                case ($urandom_range(0, 9))
                    0:       t = 13'd0;
                    1:       t = 13'd4096;
                    2:       t = 13'($urandom_range(4097, 8191));
                    3:       t = 13'($urandom_range(17, MAX_LIVE_TAPS));
                    default: t = 13'($urandom_range(1, 16));
                endcase
            write_tap_count(t);
            if (hot)
            begin
                coef_sign = 1'($urandom_range(0, 1));
                for (k = 0; k < int'(t); k++)
                    send_item(ACT_LOAD, 12'(k),
                              ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                          : (coef_sign ? Q_MAX : Q_MIN),
                              1'b0, NO_RESULT);
            end
            n = $urandom_range(6, 20);
            for (k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_sample(pick_value(hot), hot);
                else if (r < 85)
                begin
                    if ($urandom_range(0, 1) == 0)
                        idx = 12'($urandom_range(0, MAX_LIVE_TAPS + 4));
                    else
                        idx = 12'($urandom);
                    send_item(ACT_LOAD, idx, pick_value(hot), 1'b0, NO_RESULT);
                end
                else if (r < 93)
                    send_item(ACT_CLEAR, 12'($urandom), 16'($urandom), 1'b0, NO_RESULT);
                else
                    send_item(ACT_SPARE, 12'($urandom), 16'($urandom), 1'b0, NO_RESULT);
            end
        end

        drain_and_settle();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
